@@ hdl/pfa_pkg.sv @@
package pfa_pkg;

  localparam int unsigned OffW  = 16;
  localparam int unsigned PosW  = 32;
  localparam int unsigned FaceW = 32;
  localparam int unsigned TypeW = 4;
  localparam int unsigned NumCorners = 4;

  // saturation point of the per-primitive vertex counter
  localparam logic [OffW-1:0] VtxCntMax = {OffW{1'b1}};

  typedef enum logic [TypeW-1:0] {
    PRIM_POINTS     = 4'd0,
    PRIM_LINES      = 4'd1,
    PRIM_LINE_STRIP = 4'd2,
    PRIM_LINE_LOOP  = 4'd3,
    PRIM_TRIANGLES  = 4'd4,
    PRIM_TRI_STRIP  = 4'd5,
    PRIM_FAN        = 4'd6,
    PRIM_QUADS      = 4'd7,
    PRIM_QUAD_STRIP = 4'd8,
    PRIM_POLYGON    = 4'd9
  } prim_type_e;

  // one vertex request
  typedef struct packed {
    logic             start_of_geometry;
    logic             first_vertex;
    logic [TypeW-1:0] prim_type;
    logic [OffW-1:0]  prim_length;
    logic [PosW-1:0]  position_index;
  } vtx_t;

  // one face request
  typedef struct packed {
    logic [FaceW-1:0]                 face_number;
    logic                             is_quad;
    logic [NumCorners-1:0][OffW-1:0]  corner_off;
    logic [NumCorners-1:0][PosW-1:0]  corner_pos;
  } face_t;

  // assembler state carried from vertex to vertex
  typedef struct packed {
    logic [OffW-1:0]                  vtx_cnt;
    logic [1:0]                       mod3;
    logic [FaceW-1:0]                 face_cnt;
    logic [NumCorners-1:0][OffW-1:0]  slot_off;
    logic [NumCorners-1:0][PosW-1:0]  slot_pos;
    logic [TypeW-1:0]                 cur_type;
    logic [OffW-1:0]                  cur_len;
  } state_t;

endpackage

@@ hdl/pfa_if.sv @@
interface pfa_vtx_if;
  logic                        valid;
  logic                        ready;
  logic                        start_of_geometry;
  logic                        first_vertex;
  logic [pfa_pkg::TypeW-1:0]   prim_type;
  logic [pfa_pkg::OffW-1:0]    prim_length;
  logic [pfa_pkg::PosW-1:0]    position_index;

  modport source (
    output valid, start_of_geometry, first_vertex, prim_type, prim_length,
           position_index,
    input  ready
  );
  modport sink (
    input  valid, start_of_geometry, first_vertex, prim_type, prim_length,
           position_index,
    output ready
  );
endinterface

interface pfa_face_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::FaceW-1:0]   face_number;
  logic                        is_quad;
  logic [pfa_pkg::OffW-1:0]    corner0_offset;
  logic [pfa_pkg::OffW-1:0]    corner1_offset;
  logic [pfa_pkg::OffW-1:0]    corner2_offset;
  logic [pfa_pkg::OffW-1:0]    corner3_offset;
  logic [pfa_pkg::PosW-1:0]    corner0_position;
  logic [pfa_pkg::PosW-1:0]    corner1_position;
  logic [pfa_pkg::PosW-1:0]    corner2_position;
  logic [pfa_pkg::PosW-1:0]    corner3_position;

  modport source (
    output valid, face_number, is_quad, corner0_offset, corner1_offset,
           corner2_offset, corner3_offset, corner0_position, corner1_position,
           corner2_position, corner3_position,
    input  ready
  );
  modport sink (
    input  valid, face_number, is_quad, corner0_offset, corner1_offset,
           corner2_offset, corner3_offset, corner0_position, corner1_position,
           corner2_position, corner3_position,
    output ready
  );
endinterface

@@ hdl/pfa_step.sv @@
module pfa_step (
  input  pfa_pkg::state_t state_i,
  input  pfa_pkg::vtx_t   vtx_i,
  output pfa_pkg::state_t state_o,
  output pfa_pkg::face_t  face_o,
  output logic            emit_o
);

  pfa_pkg::state_t             st;
  logic                        first;
  logic                        quad;
  logic                        emit;
  logic [pfa_pkg::OffW-1:0]    k;
  logic [1:0]                  m3;
  logic [pfa_pkg::PosW-1:0]    pos;
  logic                        k_lt3;

  always_comb begin
    st    = state_i;
    pos   = vtx_i.position_index;
    first = vtx_i.start_of_geometry | vtx_i.first_vertex;
    emit  = 1'b0;
    quad  = 1'b0;

    if (vtx_i.start_of_geometry) begin
      st.face_cnt = '0;
    end
    if (first) begin
      st.cur_type = vtx_i.prim_type;
      st.cur_len  = vtx_i.prim_length;
      st.vtx_cnt  = '0;
      st.mod3     = 2'd0;
    end

    k     = st.vtx_cnt;
    m3    = st.mod3;
    k_lt3 = (k < pfa_pkg::OffW'(3));

    // vertex counter saturates, mod-3 phase only matters below the length
    if (k != pfa_pkg::VtxCntMax) begin
      st.vtx_cnt = k + pfa_pkg::OffW'(1);
    end
    st.mod3 = (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;

    if (k < st.cur_len) begin
      unique case (pfa_pkg::prim_type_e'(st.cur_type))
        pfa_pkg::PRIM_TRIANGLES: begin
          if (st.cur_len >= pfa_pkg::OffW'(3)) begin
            st.slot_off[m3] = k;
            st.slot_pos[m3] = pos;
            emit = (m3 == 2'd2);
          end
        end
        pfa_pkg::PRIM_QUADS: begin
          if (st.cur_len >= pfa_pkg::OffW'(4)) begin
            st.slot_off[k[1:0]] = k;
            st.slot_pos[k[1:0]] = pos;
            emit = (k[1:0] == 2'd3);
            quad = 1'b1;
          end
        end
        pfa_pkg::PRIM_FAN, pfa_pkg::PRIM_POLYGON: begin
          if (st.cur_len >= pfa_pkg::OffW'(3)) begin
            if (st.cur_type == pfa_pkg::PRIM_POLYGON && st.cur_len == pfa_pkg::OffW'(4)) begin
              // four-vertex polygon is a single quad
              st.slot_off[k[1:0]] = k;
              st.slot_pos[k[1:0]] = pos;
              emit = (k == pfa_pkg::OffW'(3));
              quad = 1'b1;
            end else if (k_lt3) begin
              st.slot_off[k[1:0]] = k;
              st.slot_pos[k[1:0]] = pos;
              emit = (k == pfa_pkg::OffW'(2));
            end else begin
              st.slot_off[1] = st.slot_off[2];
              st.slot_pos[1] = st.slot_pos[2];
              st.slot_off[2] = k;
              st.slot_pos[2] = pos;
              emit = 1'b1;
            end
          end
        end
        pfa_pkg::PRIM_TRI_STRIP: begin
          if (st.cur_len >= pfa_pkg::OffW'(3)) begin
            if (k_lt3) begin
              st.slot_off[k[1:0]] = k;
              st.slot_pos[k[1:0]] = pos;
              emit = (k == pfa_pkg::OffW'(2));
            end else begin
              // alternate winding by replacing the older corner
              if (k[0]) begin
                st.slot_off[0] = st.slot_off[2];
                st.slot_pos[0] = st.slot_pos[2];
              end else begin
                st.slot_off[1] = st.slot_off[2];
                st.slot_pos[1] = st.slot_pos[2];
              end
              st.slot_off[2] = k;
              st.slot_pos[2] = pos;
              // degenerate triangles are dropped
              emit = (st.slot_pos[0] != st.slot_pos[1]) &&
                     (st.slot_pos[0] != st.slot_pos[2]) &&
                     (st.slot_pos[1] != st.slot_pos[2]);
            end
          end
        end
        pfa_pkg::PRIM_QUAD_STRIP: begin
          if (st.cur_len >= pfa_pkg::OffW'(4)) begin
            quad = 1'b1;
            if (k < pfa_pkg::OffW'(2)) begin
              st.slot_off[k[1:0]] = k;
              st.slot_pos[k[1:0]] = pos;
            end else if (!k[0]) begin
              if (k >= pfa_pkg::OffW'(4)) begin
                st.slot_off[0] = st.slot_off[3];
                st.slot_pos[0] = st.slot_pos[3];
                st.slot_off[1] = st.slot_off[2];
                st.slot_pos[1] = st.slot_pos[2];
              end
              st.slot_off[3] = k;
              st.slot_pos[3] = pos;
            end else begin
              st.slot_off[2] = k;
              st.slot_pos[2] = pos;
              emit = 1'b1;
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    face_o.face_number = st.face_cnt;
    face_o.is_quad     = quad;
    face_o.corner_off  = st.slot_off;
    face_o.corner_pos  = st.slot_pos;
    if (!quad) begin
      face_o.corner_off[3] = '0;
      face_o.corner_pos[3] = '0;
    end
    if (emit) begin
      st.face_cnt = st.face_cnt + pfa_pkg::FaceW'(1);
    end
  end

  assign state_o = st;
  assign emit_o  = emit;

endmodule

@@ hdl/primitive_face_assembler_unit.sv @@
// channel   dir  modport             payload
// vtx_i     in   pfa_vtx_if.sink     geometry/primitive flags, type, length, position
// face_o    out  pfa_face_if.source  face number, quad flag, 4 corner offsets/positions
//
// one vertex per cycle sustained while no face is stalled; a face is built from its
// vertex request via the input register, then assembly logic into the face register
// the assembler state updates as the vertex leaves the input register
// rst_ni clears face numbering, vertex counter, corner slots and primitive type
// a stalled face register holds the input register; a new vertex is still
// taken while a face waits, as long as the input register is empty

module primitive_face_assembler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfa_vtx_if.sink     vtx_i,
  pfa_face_if.source  face_o
);

  // input register
  logic            in_vld_q;
  pfa_pkg::vtx_t   in_q;
  pfa_pkg::vtx_t   in_d;

  // assembler state
  pfa_pkg::state_t state_q;
  pfa_pkg::state_t state_d;

  // face register
  logic            out_vld_q;
  pfa_pkg::face_t  out_q;
  pfa_pkg::face_t  out_d;
  logic            emit;

  logic            advance;
  logic            in_ready;

  // the stage moves whenever the face register is empty or being drained;
  // any vertex, face or not, waits while a face is stuck in the face register
  assign advance  = !out_vld_q || face_o.ready;
  assign in_ready = !in_vld_q || advance;
  assign vtx_i.ready = in_ready;

  assign in_d.start_of_geometry = vtx_i.start_of_geometry;
  assign in_d.first_vertex      = vtx_i.first_vertex;
  assign in_d.prim_type         = vtx_i.prim_type;
  assign in_d.prim_length       = vtx_i.prim_length;
  assign in_d.position_index    = vtx_i.position_index;

  // per-vertex assembly: new state and the face it completes, if any
  pfa_step u_step (
    .state_i (state_q),
    .vtx_i   (in_q),
    .state_o (state_d),
    .face_o  (out_d),
    .emit_o  (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_q <= vtx_i.valid;
      end
      if (in_vld_q && advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= in_vld_q && emit;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (vtx_i.valid && in_ready) begin
      in_q <= in_d;
    end
    if (advance && in_vld_q && emit) begin
      out_q <= out_d;
    end
  end

  assign face_o.valid            = out_vld_q;
  assign face_o.face_number      = out_q.face_number;
  assign face_o.is_quad          = out_q.is_quad;
  assign face_o.corner0_offset   = out_q.corner_off[0];
  assign face_o.corner1_offset   = out_q.corner_off[1];
  assign face_o.corner2_offset   = out_q.corner_off[2];
  assign face_o.corner3_offset   = out_q.corner_off[3];
  assign face_o.corner0_position = out_q.corner_pos[0];
  assign face_o.corner1_position = out_q.corner_pos[1];
  assign face_o.corner2_position = out_q.corner_pos[2];
  assign face_o.corner3_position = out_q.corner_pos[3];

endmodule

@@ bench/primitive_face_assembler_unit_tb.sv @@
module primitive_face_assembler_unit_tb;

  // codes above the polygon are not primitive types; the top one marks them here
  localparam logic [pfa_pkg::TypeW-1:0] PRIM_CODE_TOP = {pfa_pkg::TypeW{1'b1}};

  localparam int RandItems  = 420;
  localparam int DrainWait  = 8;     // a face passes the input and face registers
  localparam int HoldOff    = 80;    // long receiver stall, fills the pipe
  localparam int IdleLimit  = 2000;  // cycles with no request moving on either side

  // one row of the directed stimulus table
  typedef struct {
    pfa_pkg::vtx_t  vtx;
    bit             typed;     // expectation written into the row itself
    bit             hit;       // typed row: a face is expected
    pfa_pkg::face_t face;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pfa_vtx_if  vtx_if ();
  pfa_face_if face_if ();

  primitive_face_assembler_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_if),
    .face_o (face_if)
  );

  // assembler state as predicted from the vertex requests taken so far
  logic [pfa_pkg::OffW-1:0]  asm_vcnt;
  logic [pfa_pkg::FaceW-1:0] asm_fcnt;
  logic [pfa_pkg::OffW-1:0]  asm_soff [pfa_pkg::NumCorners];
  logic [pfa_pkg::PosW-1:0]  asm_spos [pfa_pkg::NumCorners];
  logic [pfa_pkg::TypeW-1:0] asm_type;
  logic [pfa_pkg::OffW-1:0]  asm_len;

  pfa_pkg::face_t faces_due [$];
  stim_row_t      stim_rows [$];
  int             mismatches;
  int             vertices_sent;
  int             burst_left;
  int             idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // face predictor
  // ---------------------------------------------------------------------------

  // predicted state starts where the block's reset leaves it
  function automatic void asm_clear();
    asm_vcnt = '0;
    asm_fcnt = '0;
    asm_type = '0;
    asm_len  = '0;
    for (int i = 0; i < pfa_pkg::NumCorners; i++) begin
      asm_soff[i] = '0;
      asm_spos[i] = '0;
    end
  endfunction

  function automatic void put_slot(input int s, input logic [pfa_pkg::OffW-1:0] off,
                                   input logic [pfa_pkg::PosW-1:0] pos);
    asm_soff[s] = off;
    asm_spos[s] = pos;
  endfunction

  function automatic void copy_slot(input int dst, input int src);
    asm_soff[dst] = asm_soff[src];
    asm_spos[dst] = asm_spos[src];
  endfunction

  // advances the predicted state by one vertex; returns 1 when it completes a face
  function automatic bit predict_face(input pfa_pkg::vtx_t v, output pfa_pkg::face_t f);
    logic [pfa_pkg::OffW-1:0] k;
    bit hit;
    bit quad;
    hit  = 1'b0;
    quad = 1'b0;
    f    = '0;
    // start of geometry clears face numbering and opens a primitive too
    if (v.start_of_geometry) asm_fcnt = '0;
    if (v.start_of_geometry || v.first_vertex) begin
      asm_type = v.prim_type;
      asm_len  = v.prim_length;
      asm_vcnt = '0;
    end
    k = asm_vcnt;
    if (asm_vcnt != pfa_pkg::VtxCntMax) asm_vcnt = asm_vcnt + pfa_pkg::OffW'(1);
    // vertices past the latched length touch no slot and make no face
    if (k < asm_len) begin
      case (asm_type)
        pfa_pkg::PRIM_TRIANGLES: if (asm_len >= 3) begin
          put_slot(int'(k % 3), k, v.position_index);
          hit = (k % 3 == 2);
        end
        pfa_pkg::PRIM_QUADS: if (asm_len >= 4) begin
          put_slot(int'(k[1:0]), k, v.position_index);
          hit  = (k[1:0] == 2'd3);
          quad = 1'b1;
        end
        pfa_pkg::PRIM_FAN, pfa_pkg::PRIM_POLYGON: if (asm_len >= 3) begin
          if (asm_type == pfa_pkg::PRIM_POLYGON && asm_len == 4) begin
            // four-corner polygon comes out as a single quad
            put_slot(int'(k[1:0]), k, v.position_index);
            hit  = (k == 3);
            quad = 1'b1;
          end else if (k < 3) begin
            put_slot(int'(k), k, v.position_index);
            hit = (k == 2);
          end else begin
            copy_slot(1, 2);
            put_slot(2, k, v.position_index);
            hit = 1'b1;
          end
        end
        pfa_pkg::PRIM_TRI_STRIP: if (asm_len >= 3) begin
          if (k < 3) begin
            put_slot(int'(k), k, v.position_index);
            hit = (k == 2);
          end else begin
            // winding alternates with the vertex parity
            if (k[0]) copy_slot(0, 2);
            else      copy_slot(1, 2);
            put_slot(2, k, v.position_index);
            // degenerate triangles are dropped, slots still move on
            hit = (asm_spos[0] != asm_spos[1]) && (asm_spos[0] != asm_spos[2]) &&
                  (asm_spos[1] != asm_spos[2]);
          end
        end
        pfa_pkg::PRIM_QUAD_STRIP: if (asm_len >= 4) begin
          if (k < 2) begin
            put_slot(int'(k), k, v.position_index);
          end else if (!k[0]) begin
            if (k >= 4) begin
              copy_slot(0, 3);
              copy_slot(1, 2);
            end
            put_slot(3, k, v.position_index);
          end else begin
            put_slot(2, k, v.position_index);
            hit  = 1'b1;
            quad = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (hit) begin
      f.face_number = asm_fcnt;
      f.is_quad     = quad;
      // triangles leave the fourth corner at zero
      for (int i = 0; i < pfa_pkg::NumCorners; i++) begin
        if (quad || i < 3) begin
          f.corner_off[i] = asm_soff[i];
          f.corner_pos[i] = asm_spos[i];
        end
      end
      asm_fcnt = asm_fcnt + pfa_pkg::FaceW'(1);
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // vertex sender
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk_row(input bit sog, input bit first,
                                       input logic [pfa_pkg::TypeW-1:0] typ,
                                       input logic [pfa_pkg::OffW-1:0] len,
                                       input logic [pfa_pkg::PosW-1:0] pos,
                                       input bit typed, input bit hit,
                                       input pfa_pkg::face_t face);
    stim_row_t r;
    r.vtx.start_of_geometry = sog;
    r.vtx.first_vertex      = first;
    r.vtx.prim_type         = typ;
    r.vtx.prim_length       = len;
    r.vtx.position_index    = pos;
    r.typed = typed;
    r.hit   = hit;
    r.face  = face;
    return r;
  endfunction

  // offers one vertex request, waits for it to be taken, files the expected face
  // and then either keeps valid up for the next one or opens a gap
  task automatic send_vertex(input pfa_pkg::vtx_t v, input bit typed, input bit typed_hit,
                             input pfa_pkg::face_t typed_face);
    pfa_pkg::face_t f;
    bit             hit;
    vtx_if.valid             <= 1'b1;
    vtx_if.start_of_geometry <= v.start_of_geometry;
    vtx_if.first_vertex      <= v.first_vertex;
    vtx_if.prim_type         <= v.prim_type;
    vtx_if.prim_length       <= v.prim_length;
    vtx_if.position_index    <= v.position_index;
    @(posedge clk_i);
    while (!vtx_if.ready) @(posedge clk_i);
    // the predictor always runs so its state stays in step with the block
    hit = predict_face(v, f);
    if (typed) begin
      hit = typed_hit;
      f   = typed_face;
    end
    if (hit) faces_due.push_back(f);
    vertices_sent++;
    if (burst_left == 0) begin
      vtx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // now and then a long burst, so stretches without gaps occur
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pfa_pkg::vtx_t             v;
    logic [pfa_pkg::TypeW-1:0] typ;
    logic [pfa_pkg::OffW-1:0]  len;
    int                        nvtx;
    bit                        sog;
    bit                        small_pool;
    rst_ni                   = 1'b0;
    vtx_if.valid             <= 1'b0;
    vtx_if.start_of_geometry <= 1'b0;
    vtx_if.first_vertex      <= 1'b0;
    vtx_if.prim_type         <= pfa_pkg::PRIM_POINTS;
    vtx_if.prim_length       <= '0;
    vtx_if.position_index    <= '0;
    mismatches    = 0;
    vertices_sent = 0;
    burst_left    = 0;
    asm_clear();

    // directed rows: no primitive opened yet, triangle with position extremes,
    // excess vertex, quads, short primitive, strip with a degenerate triangle,
    // quad strip, fan, four-corner polygon, non-face and unknown types
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRIANGLES, 16'd3, 32'd7,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, pfa_pkg::PRIM_TRIANGLES, 16'd3, 32'd0,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRIANGLES, 16'd3, 32'hFFFF_FFFF,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRIANGLES, 16'd3, 32'd5,
                               1'b1, 1'b1,
      '{face_number: 32'd0, is_quad: 1'b0,
        corner_off: {16'd0, 16'd2, 16'd1, 16'd0},
        corner_pos: {32'd0, 32'd5, 32'hFFFF_FFFF, 32'd0}}));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRIANGLES, 16'd3, 32'd9,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b1, pfa_pkg::PRIM_QUADS, 16'd4, 32'd10,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_QUADS, 16'd4, 32'd11,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_QUADS, 16'd4, 32'd12,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_QUADS, 16'd4, 32'd13,
                               1'b1, 1'b1,
      '{face_number: 32'd1, is_quad: 1'b1,
        corner_off: {16'd3, 16'd2, 16'd1, 16'd0},
        corner_pos: {32'd13, 32'd12, 32'd11, 32'd10}}));
    stim_rows.push_back(mk_row(1'b0, 1'b1, pfa_pkg::PRIM_TRIANGLES, 16'd2, 32'd1,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRIANGLES, 16'd2, 32'd2,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b1, pfa_pkg::PRIM_TRI_STRIP, 16'd5, 32'd1,
                               1'b0, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRI_STRIP, 16'd5, 32'd2,
                               1'b0, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRI_STRIP, 16'd5, 32'd3,
                               1'b0, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRI_STRIP, 16'd5, 32'd2,
                               1'b0, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b0, pfa_pkg::PRIM_TRI_STRIP, 16'd5, 32'd4,
                               1'b0, 1'b0, '0));
    for (int i = 0; i < 4; i++)
      stim_rows.push_back(mk_row(1'b0, i == 0, pfa_pkg::PRIM_QUAD_STRIP, 16'd4,
                                 32'(20 + i), 1'b0, 1'b0, '0));
    for (int i = 0; i < 4; i++)
      stim_rows.push_back(mk_row(1'b0, i == 0, pfa_pkg::PRIM_FAN, 16'd4,
                                 32'(30 + i), 1'b0, 1'b0, '0));
    for (int i = 0; i < 4; i++)
      stim_rows.push_back(mk_row(1'b0, i == 0, pfa_pkg::PRIM_POLYGON, 16'd4,
                                 32'(40 + i), 1'b0, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b1, 1'b1, pfa_pkg::PRIM_LINES, 16'hFFFF, 32'd0,
                               1'b1, 1'b0, '0));
    stim_rows.push_back(mk_row(1'b0, 1'b1, PRIM_CODE_TOP, 16'hFFFF, 32'd1,
                               1'b1, 1'b0, '0));

    // reset once, asynchronous assert, released on a clock edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      send_vertex(stim_rows[i].vtx, stim_rows[i].typed, stim_rows[i].hit,
                  stim_rows[i].face);

    // random part: mostly whole primitives with random content, some broken
    // ones (cut short or overlong) and some stray vertices
    while (vertices_sent < stim_rows.size() + RandItems) begin
      if ($urandom_range(0, 15) == 0) begin
        v.start_of_geometry = 1'($urandom);
        v.first_vertex      = 1'($urandom);
        v.prim_type         = pfa_pkg::TypeW'($urandom);
        v.prim_length       = pfa_pkg::OffW'($urandom);
        v.position_index    = pfa_pkg::PosW'($urandom);
        send_vertex(v, 1'b0, 1'b0, '0);
      end else begin
        typ = ($urandom_range(0, 9) == 0)
                ? pfa_pkg::TypeW'($urandom_range(0, PRIM_CODE_TOP))
                : pfa_pkg::TypeW'($urandom_range(pfa_pkg::PRIM_TRIANGLES,
                                                 pfa_pkg::PRIM_POLYGON));
        case ($urandom_range(0, 9))
          0:       len = pfa_pkg::OffW'($urandom_range(0, 3));
          1:       len = pfa_pkg::OffW'($urandom);
          default: len = pfa_pkg::OffW'($urandom_range(3, 10));
        endcase
        if (len > 12)                        nvtx = $urandom_range(1, 12);
        else if ($urandom_range(0, 5) == 0)  nvtx = $urandom_range(0, len + 2);
        else                                 nvtx = len;
        sog        = ($urandom_range(0, 7) == 0);
        // a tiny pool of positions makes degenerate strip triangles common
        small_pool = 1'($urandom_range(0, 1));
        for (int i = 0; i < nvtx; i++) begin
          v.start_of_geometry = (i == 0) ? sog : 1'b0;
          v.first_vertex      = (i == 0);
          // type and length on later vertices are ignored, so they are junk
          v.prim_type         = (i == 0) ? typ : pfa_pkg::TypeW'($urandom);
          v.prim_length       = (i == 0) ? len : pfa_pkg::OffW'($urandom);
          v.position_index    = small_pool ? pfa_pkg::PosW'($urandom_range(0, 3))
                                           : pfa_pkg::PosW'($urandom);
          send_vertex(v, 1'b0, 1'b0, '0);
        end
      end
    end

    vtx_if.valid <= 1'b0;
    while (faces_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS primitive_face_assembler_unit");
    end else begin
      $display("FAIL primitive_face_assembler_unit");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // face receiver: segments of steady ready, random stalls, one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int seg;
    int mode;
    face_if.ready <= 1'b0;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg == 5) begin
        // long stall while the sender keeps offering: the block backs up
        face_if.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(10, 60)) begin
          case (mode)
            0:       face_if.ready <= 1'b1;
            1:       face_if.ready <= ($urandom_range(0, 3) != 0);
            default: face_if.ready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // face checker: compares every accepted face with the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    pfa_pkg::face_t got;
    pfa_pkg::face_t want;
    if (rst_ni && face_if.valid && face_if.ready) begin
      got.face_number   = face_if.face_number;
      got.is_quad       = face_if.is_quad;
      got.corner_off[0] = face_if.corner0_offset;
      got.corner_off[1] = face_if.corner1_offset;
      got.corner_off[2] = face_if.corner2_offset;
      got.corner_off[3] = face_if.corner3_offset;
      got.corner_pos[0] = face_if.corner0_position;
      got.corner_pos[1] = face_if.corner1_position;
      got.corner_pos[2] = face_if.corner2_position;
      got.corner_pos[3] = face_if.corner3_position;
      if (faces_due.size() == 0) begin
        mismatches++;
        $display("%0t: face %0h arrived, expected none, got quad %0b", $time,
                 got.face_number, got.is_quad);
      end else begin
        want = faces_due.pop_front();
        check_field("face_number", want.face_number, got.face_number);
        check_field("is_quad", 32'(want.is_quad), 32'(got.is_quad));
        for (int i = 0; i < pfa_pkg::NumCorners; i++) begin
          check_field($sformatf("corner%0d_offset", i), 32'(want.corner_off[i]),
                      32'(got.corner_off[i]));
          check_field($sformatf("corner%0d_position", i), want.corner_pos[i],
                      got.corner_pos[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any request moving ends the run
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((vtx_if.valid && vtx_if.ready) || (face_if.valid && face_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL primitive_face_assembler_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
